// ===== sv/qlm_pkg.sv =====
// ----------------------------------------------------------------------------
// qlm_pkg
// Shared types and constants of the queued lock manager: command and status
// codes, field widths and the control/status bundles between FSM and datapath.
// ----------------------------------------------------------------------------
package qlm_pkg;

   localparam int DEF_LOCK_COUNT  = 256;
   localparam int DEF_NUM_WAITERS = 64;
   localparam int DEF_RANK_BITS   = 8;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 8;
   localparam int REQ_W    = 8;
   localparam int STATUS_W = 3;
   localparam int GRANT_W  = 8;
   localparam int HELD_W   = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_ACQUIRE = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_FREED   = 3'd2,
      ST_IGNORED = 3'd3,
      ST_CREATED = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic rd_lock;
      logic rd_wait;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
   } dp_status_type;

endpackage

// ===== sv/qlm_ctrl.sv =====
// ----------------------------------------------------------------------------
// qlm_ctrl
// Sequencer: table clearing after reset, then capture, lock read, waiter
// read and commit for each beat; owns the result valid flag.
// ----------------------------------------------------------------------------
module qlm_ctrl
   import qlm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctl_cmd_type   ctl_cmd,
   input  dp_status_type dp_status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD1,
      S_RD2,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl_cmd.clear   = (state_ff == S_CLEAR);
      ctl_cmd.capture = (state_ff == S_IDLE) && req_valid;
      ctl_cmd.rd_lock = (state_ff == S_RD1);
      ctl_cmd.rd_wait = (state_ff == S_RD2);
      ctl_cmd.exec    = (state_ff == S_EXEC) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (dp_status.clear_done) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_EXEC;
         S_EXEC:  if (out_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      priority if (ctl_cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/qlm_datapath.sv =====
// ----------------------------------------------------------------------------
// qlm_datapath
// Lock table, waiter pool and free-slot stack in synchronous memories, the
// request capture, the per-command update and the result register.
// ----------------------------------------------------------------------------
module qlm_datapath
   import qlm_pkg::*;
#(
   parameter int LOCK_COUNT  = DEF_LOCK_COUNT,
   parameter int NUM_WAITERS = DEF_NUM_WAITERS,
   parameter int RANK_BITS   = DEF_RANK_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         ctl_cmd,
   output dp_status_type       dp_status,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ID_W-1:0]     req_lock_id,
   input  logic [REQ_W-1:0]    req_requester,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [GRANT_W-1:0]  rsp_grant_rank,
   output logic [ID_W-1:0]     rsp_lock_echo,
   output logic [HELD_W-1:0]   rsp_held_total
);

   localparam int LOCK_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
   localparam int SLOT_W = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
   localparam int CNT_W  = $clog2(NUM_WAITERS + 1);
   localparam int RW     = (RANK_BITS < REQ_W) ? RANK_BITS : REQ_W;
   localparam int CLR_N  = (LOCK_COUNT > NUM_WAITERS) ? LOCK_COUNT : NUM_WAITERS;
   localparam int CLR_W  = $clog2(CLR_N);
   // lock entry: present, held, queue non-empty, head, tail
   localparam int ENT_W  = 3 + 2 * SLOT_W;

   logic [ENT_W-1:0]  lock_mem [LOCK_COUNT];
   logic [RW-1:0]     wrank_mem [NUM_WAITERS];
   logic [SLOT_W-1:0] wnext_mem [NUM_WAITERS];
   logic [SLOT_W-1:0] free_mem [NUM_WAITERS];

   logic [CLR_W-1:0]    clr_cnt_ff;
   logic [CNT_W-1:0]    free_count_ff, free_count_in;
   logic [HELD_W-1:0]   held_ff, held_in;

   logic [CMD_W-1:0]    cmd_ff;
   logic [ID_W-1:0]     id_ff;
   logic [RW-1:0]       rank_ff;

   logic [ENT_W-1:0]    lock_rd_ff;
   logic [SLOT_W-1:0]   free_rd_ff;
   logic [RW-1:0]       wrank_rd_ff;
   logic [SLOT_W-1:0]   wnext_rd_ff;

   logic [STATUS_W-1:0] status_ff;
   logic [GRANT_W-1:0]  grant_ff;
   logic [ID_W-1:0]     echo_ff;
   logic [HELD_W-1:0]   total_ff;

   logic [LOCK_W-1:0]   lock_idx;
   logic                id_ok;
   logic                e_present, e_held, e_nonempty;
   logic [SLOT_W-1:0]   e_head, e_tail;
   logic                n_held, n_nonempty;
   logic [SLOT_W-1:0]   n_head, n_tail;
   logic                lk_we, rank_we, next_we, push_we;
   logic [SLOT_W-1:0]   next_addr;
   status_type          status_in;
   logic [GRANT_W-1:0]  grant_in;

   assign lock_idx = LOCK_W'(id_ff);
   assign id_ok    = (32'(id_ff) < LOCK_COUNT);

   assign e_present  = lock_rd_ff[ENT_W-1];
   assign e_held     = lock_rd_ff[ENT_W-2];
   assign e_nonempty = lock_rd_ff[ENT_W-3];
   assign e_head     = lock_rd_ff[2*SLOT_W-1:SLOT_W];
   assign e_tail     = lock_rd_ff[SLOT_W-1:0];

   assign dp_status.clear_done = (32'(clr_cnt_ff) == CLR_N - 1);

   always_comb begin
      status_in     = ST_IGNORED;
      grant_in      = '0;
      n_held        = e_held;
      n_nonempty    = e_nonempty;
      n_head        = e_head;
      n_tail        = e_tail;
      lk_we         = 1'b0;
      rank_we       = 1'b0;
      next_we       = 1'b0;
      push_we       = 1'b0;
      next_addr     = e_tail;
      free_count_in = free_count_ff;
      held_in       = held_ff;
      unique case (cmd_type'(cmd_ff))
         CMD_CREATE: begin
            if (id_ok && !e_present) begin
               n_held     = 1'b0;
               n_nonempty = 1'b0;
               lk_we      = 1'b1;
               status_in  = ST_CREATED;
            end
         end
         CMD_ACQUIRE: begin
            if (id_ok && e_present) begin
               priority if (!e_held) begin
                  n_held    = 1'b1;
                  lk_we     = 1'b1;
                  held_in   = held_ff + 1'b1;
                  status_in = ST_GRANTED;
                  grant_in  = GRANT_W'(rank_ff);
               end else if (free_count_ff == '0) begin
                  status_in = ST_FULL;
               end else begin
                  rank_we       = 1'b1;
                  next_we       = e_nonempty;
                  if (!e_nonempty) n_head = free_rd_ff;
                  n_nonempty    = 1'b1;
                  n_tail        = free_rd_ff;
                  lk_we         = 1'b1;
                  free_count_in = free_count_ff - 1'b1;
                  status_in     = ST_QUEUED;
               end
            end
         end
         CMD_RELEASE: begin
            if (id_ok && e_present && e_held) begin
               lk_we = 1'b1;
               if (!e_nonempty) begin
                  n_held    = 1'b0;
                  if (held_ff != '0) held_in = held_ff - 1'b1;
                  status_in = ST_FREED;
               end else begin
                  grant_in = GRANT_W'(wrank_rd_ff);
                  if (e_head == e_tail) n_nonempty = 1'b0;
                  else n_head = wnext_rd_ff;
                  push_we       = 1'b1;
                  free_count_in = free_count_ff + 1'b1;
                  status_in     = ST_GRANTED;
               end
            end
         end
         default: status_in = ST_IGNORED;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (ctl_cmd.clear) begin
         if (32'(clr_cnt_ff) < LOCK_COUNT) lock_mem[clr_cnt_ff[LOCK_W-1:0]] <= '0;
      end else if (ctl_cmd.exec && lk_we) begin
         lock_mem[lock_idx] <= {1'b1, n_held, n_nonempty, n_head, n_tail};
      end
      if (ctl_cmd.rd_lock) lock_rd_ff <= lock_mem[lock_idx];
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.clear) begin
         if (32'(clr_cnt_ff) < NUM_WAITERS)
            free_mem[clr_cnt_ff[SLOT_W-1:0]] <= clr_cnt_ff[SLOT_W-1:0];
      end else if (ctl_cmd.exec && push_we) begin
         free_mem[SLOT_W'(free_count_ff)] <= e_head;
      end
      if (ctl_cmd.rd_lock) free_rd_ff <= free_mem[SLOT_W'(free_count_ff - 1'b1)];
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.exec && rank_we) wrank_mem[free_rd_ff] <= rank_ff;
      if (ctl_cmd.rd_wait) wrank_rd_ff <= wrank_mem[e_head];
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.exec && next_we) wnext_mem[next_addr] <= free_rd_ff;
      if (ctl_cmd.rd_wait) wnext_rd_ff <= wnext_mem[e_head];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff    <= '0;
         free_count_ff <= CNT_W'(NUM_WAITERS);
         held_ff       <= '0;
      end else begin
         if (ctl_cmd.clear && !dp_status.clear_done) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (ctl_cmd.exec) begin
            free_count_ff <= free_count_in;
            held_ff       <= held_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         cmd_ff  <= req_cmd;
         id_ff   <= req_lock_id;
         rank_ff <= RW'(req_requester);
      end
      if (ctl_cmd.exec) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         echo_ff   <= id_ff;
         total_ff  <= held_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_grant_rank = grant_ff;
   assign rsp_lock_echo  = echo_ff;
   assign rsp_held_total = total_ff;

endmodule

// ===== sv/queued_lock_manager_unit.sv =====
// Sequencing: a request beat is captured, then the sequencer reads the lock
// entry, then the head waiter, then commits the result beat (held while the
// result side stalls); one command is in flight, so no new beat is taken until it commits.
// Reset: synchronous; afterwards a clearing pass over max(LOCK_COUNT,
// NUM_WAITERS) entries (256 by default) runs through the lock table and slot
// stack, with req_stall held high until it finishes.
// ----------------------------------------------------------------------------
// queued_lock_manager_unit
// Lock server with per-lock FIFO waiter queues in a shared slot pool.
// ----------------------------------------------------------------------------
module queued_lock_manager_unit
   import qlm_pkg::*;
#(
   parameter int LOCK_COUNT  = DEF_LOCK_COUNT,
   parameter int NUM_WAITERS = DEF_NUM_WAITERS,
   parameter int RANK_BITS   = DEF_RANK_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ID_W-1:0]     req_lock_id,
   input  logic [REQ_W-1:0]    req_requester,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [GRANT_W-1:0]  rsp_grant_rank,
   output logic [ID_W-1:0]     rsp_lock_echo,
   output logic [HELD_W-1:0]   rsp_held_total
);

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   qlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_cmd   (ctl_cmd),
      .dp_status (dp_status)
   );

   qlm_datapath #(
      .LOCK_COUNT  (LOCK_COUNT),
      .NUM_WAITERS (NUM_WAITERS),
      .RANK_BITS   (RANK_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl_cmd        (ctl_cmd),
      .dp_status      (dp_status),
      .req_cmd        (req_cmd),
      .req_lock_id    (req_lock_id),
      .req_requester  (req_requester),
      .rsp_status     (rsp_status),
      .rsp_grant_rank (rsp_grant_rank),
      .rsp_lock_echo  (rsp_lock_echo),
      .rsp_held_total (rsp_held_total)
   );

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.clear |-> req_stall)
      else $error("request taken during clearing pass");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.exec |-> (!rsp_valid || !rsp_stall))
      else $error("commit over a stalled result");

   a_commit_gives_beat: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.exec |=> rsp_valid)
      else $error("commit without result beat");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_GRANTED)) |-> (rsp_grant_rank == '0))
      else $error("grant rank set on non-grant result");

endmodule
